// ===== hdl/i2cmbe_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmbe_pkg
// Shared codes and pin tables for the I2C master bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cmbe_pkg;

   localparam int unsigned CmdWidth   = 4;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned AddrWidth  = 7;
   localparam int unsigned TickWidth  = 8;
   localparam int unsigned PhaseWidth = 3;
   localparam int unsigned BitsWidth  = 4;
   localparam int unsigned CsrIdxWidth = 2;

   typedef logic [CmdWidth-1:0]   cmd_type;
   typedef logic [ByteWidth-1:0]  byte_type;
   typedef logic [TickWidth-1:0]  tick_type;
   typedef logic [PhaseWidth-1:0] phase_type;
   typedef logic [BitsWidth-1:0]  bits_type;

   // command codes
   localparam cmd_type CMD_NONE       = 4'd0;
   localparam cmd_type CMD_RELEASE    = 4'd1;
   localparam cmd_type CMD_START      = 4'd2;
   localparam cmd_type CMD_RESTART    = 4'd3;
   localparam cmd_type CMD_STOP       = 4'd4;
   localparam cmd_type CMD_ACK        = 4'd5;
   localparam cmd_type CMD_NAK        = 4'd6;
   localparam cmd_type CMD_WRITE      = 4'd7;
   localparam cmd_type CMD_READ       = 4'd8;
   localparam cmd_type CMD_ADDR_WRITE = 4'd9;
   localparam cmd_type CMD_ADDR_READ  = 4'd10;

   // register indexes
   localparam logic [CsrIdxWidth-1:0] CSR_DEVICE_ADDRESS = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_PHASE_TICKS    = 2'd1;

   // pin actions
   typedef logic [1:0] pin_act_type;
   localparam pin_act_type PIN_SDA_LOW  = 2'd0;
   localparam pin_act_type PIN_SDA_HIGH = 2'd1;
   localparam pin_act_type PIN_SCL_LOW  = 2'd2;
   localparam pin_act_type PIN_SCL_HIGH = 2'd3;

   // byte transfer: 8 data bits, then the ACK slot
   localparam bits_type DATA_BITS = 4'd8;
   localparam bits_type SLOT_BITS = 4'd9;

   function automatic logic is_byte_write(input cmd_type op);
      return (op == CMD_WRITE) || (op == CMD_ADDR_WRITE) || (op == CMD_ADDR_READ);
   endfunction

   function automatic logic is_pin_op(input cmd_type op);
      return (op >= CMD_RELEASE) && (op <= CMD_NAK);
   endfunction

   // number of phases of a fixed pin sequence
   function automatic phase_type pin_len(input cmd_type op);
      phase_type len;
      len = 3'd4;
      if (op == CMD_RELEASE || op == CMD_START) begin
         len = 3'd2;
      end
      return len;
   endfunction

   // pin action of a fixed sequence at a given phase
   function automatic pin_act_type pin_action(input cmd_type op, input logic [1:0] idx);
      pin_act_type act;
      act = PIN_SDA_LOW;
      case (op)
         CMD_RELEASE: begin
            if (idx == 2'd0) act = PIN_SDA_HIGH;
            else if (idx == 2'd1) act = PIN_SCL_HIGH;
         end
         CMD_START: begin
            if (idx == 2'd1) act = PIN_SCL_LOW;
         end
         CMD_RESTART: begin
            case (idx)
               2'd0: act = PIN_SDA_HIGH;
               2'd1: act = PIN_SCL_HIGH;
               2'd2: act = PIN_SDA_LOW;
               default: act = PIN_SCL_LOW;
            endcase
         end
         CMD_STOP: begin
            case (idx)
               2'd0: act = PIN_SCL_LOW;
               2'd1: act = PIN_SDA_LOW;
               2'd2: act = PIN_SCL_HIGH;
               default: act = PIN_SDA_HIGH;
            endcase
         end
         CMD_ACK: begin
            case (idx)
               2'd0: act = PIN_SDA_LOW;
               2'd1: act = PIN_SCL_HIGH;
               2'd2: act = PIN_SCL_LOW;
               default: act = PIN_SDA_HIGH;
            endcase
         end
         CMD_NAK: begin
            case (idx)
               2'd0: act = PIN_SDA_HIGH;
               2'd1: act = PIN_SCL_HIGH;
               2'd2: act = PIN_SCL_LOW;
               default: act = PIN_SDA_HIGH;
            endcase
         end
         default: act = PIN_SDA_LOW;
      endcase
      return act;
   endfunction

endpackage

`default_nettype wire

// ===== hdl/i2c_master_bit_engine_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// Single-master I2C bit engine driven by one timebase tick per request word.
// ----------------------------------------------------------------------------
// Every request word is one tick of the timebase. The engine takes one word
// per clock cycle and answers each with exactly one response word through a
// single output register; the request side stalls only while that register
// holds a word the consumer has not taken. A command is taken only while the
// engine is idle; each pin phase lasts phase_ticks ticks (zero acts as one).
// Bytes go out MSB first followed by the ACK slot; reads and the ACK slot
// keep the SDA level of the last tick of the SCL-high phase.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine_unit
   import i2cmbe_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // request channel
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [CmdWidth-1:0]    req_command,
   input  wire logic [ByteWidth-1:0]   req_write_data,
   input  wire logic                   req_sda_in,
   // response channel
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic                        rsp_scl_level,
   output logic                        rsp_sda_level,
   output logic                        rsp_busy_res,
   output logic                        rsp_done_res,
   output logic [ByteWidth-1:0]        rsp_read_byte,
   output logic                        rsp_ack_bit,
   // configuration channel
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CsrIdxWidth-1:0] csr_index,
   input  wire logic [TickWidth-1:0]   csr_wdata
);

   logic [AddrWidth-1:0] dev_addr_ff;
   tick_type             phase_ticks_ff;

   cmd_type   op_ff,    op_in;
   phase_type phase_ff, phase_in;
   tick_type  timer_ff, timer_in;
   bits_type  bits_ff,  bits_in;
   byte_type  shift_ff, shift_in;
   logic      scl_ff,   scl_in;
   logic      sda_ff,   sda_in;
   byte_type  read_ff,  read_in;
   logic      ack_ff,   ack_in;
   logic      done_in;

   logic        rsp_valid_ff;
   logic        rsp_scl_ff, rsp_sda_ff, rsp_busy_ff, rsp_done_ff, rsp_ack_ff;
   byte_type    rsp_read_ff;

   logic        req_fire;
   logic        do_enter;
   logic        do_sample;
   logic        entered;
   tick_type    load_value;
   pin_act_type act;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;

   assign load_value = (phase_ticks_ff == '0) ? '0 : phase_ticks_ff - tick_type'(1);

   // next state for one tick
   always_comb begin
      op_in     = op_ff;
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      bits_in   = bits_ff;
      shift_in  = shift_ff;
      scl_in    = scl_ff;
      sda_in    = sda_ff;
      read_in   = read_ff;
      ack_in    = ack_ff;
      done_in   = 1'b0;
      do_enter  = 1'b0;
      do_sample = 1'b0;
      entered   = 1'b0;
      act       = PIN_SDA_LOW;

      if (op_ff == CMD_NONE) begin
         if (req_command >= CMD_RELEASE && req_command <= CMD_ADDR_READ) begin
            op_in    = req_command;
            phase_in = '0;
            bits_in  = '0;
            if (req_command == CMD_WRITE) begin
               shift_in = req_write_data;
            end else if (req_command == CMD_ADDR_WRITE) begin
               shift_in = {dev_addr_ff, 1'b0};
            end else if (req_command == CMD_ADDR_READ) begin
               shift_in = {dev_addr_ff, 1'b1};
            end else begin
               shift_in = '0;
            end
            do_enter = 1'b1;
         end
      end else if (timer_ff != '0) begin
         timer_in  = timer_ff - tick_type'(1);
         do_sample = 1'b1;
      end else begin
         // advance to the next phase or finish
         phase_in = phase_ff + phase_type'(1);
         if (is_pin_op(op_ff)) begin
            done_in = (phase_in >= pin_len(op_ff));
         end else if (is_byte_write(op_ff)) begin
            if (phase_in >= 3'd3) begin
               phase_in = '0;
               bits_in  = bits_ff + bits_type'(1);
               done_in  = (bits_in >= SLOT_BITS);
            end
         end else begin
            if (phase_in >= 3'd2) begin
               phase_in = '0;
               bits_in  = bits_ff + bits_type'(1);
               if (bits_in >= DATA_BITS) begin
                  read_in = shift_ff;
                  done_in = 1'b1;
               end
            end
         end
         if (done_in) begin
            op_in    = CMD_NONE;
            phase_in = '0;
            bits_in  = '0;
            timer_in = '0;
         end else begin
            do_enter = 1'b1;
         end
      end

      // apply the pin action of the phase just entered
      if (do_enter) begin
         if (is_pin_op(op_in)) begin
            act = pin_action(op_in, phase_in[1:0]);
            if (act == PIN_SDA_LOW || act == PIN_SDA_HIGH) begin
               sda_in = act[0];
            end else begin
               scl_in = act[0];
            end
         end else if (is_byte_write(op_in)) begin
            if (phase_in == 3'd0) begin
               sda_in = (bits_in < DATA_BITS) ? shift_in[ByteWidth-1] : 1'b1;
            end else if (phase_in == 3'd1) begin
               scl_in = 1'b1;
            end else begin
               scl_in = 1'b0;
               if (bits_in < DATA_BITS) begin
                  shift_in = {shift_in[ByteWidth-2:0], 1'b0};
               end
            end
         end else if (op_in == CMD_READ) begin
            scl_in = (phase_in == 3'd0);
         end
         timer_in  = load_value;
         do_sample = 1'b1;
         entered   = 1'b1;
      end

      // sample SDA while SCL is high
      if (do_sample) begin
         if (op_in == CMD_READ && phase_in == 3'd0) begin
            if (entered) begin
               shift_in = {shift_in[ByteWidth-2:0], req_sda_in};
            end else begin
               shift_in = {shift_in[ByteWidth-1:1], req_sda_in};
            end
         end else if (is_byte_write(op_in) && bits_in == DATA_BITS && phase_in == 3'd1) begin
            ack_in = req_sda_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff    <= '0;
         phase_ticks_ff <= tick_type'(1);
         op_ff          <= CMD_NONE;
         phase_ff       <= '0;
         timer_ff       <= '0;
         bits_ff        <= '0;
         shift_ff       <= '0;
         scl_ff         <= 1'b1;
         sda_ff         <= 1'b1;
         read_ff        <= '0;
         ack_ff         <= 1'b1;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_DEVICE_ADDRESS) begin
               dev_addr_ff <= csr_wdata[AddrWidth-1:0];
            end else if (csr_index == CSR_PHASE_TICKS) begin
               phase_ticks_ff <= csr_wdata;
            end
         end
         if (req_fire) begin
            op_ff        <= op_in;
            phase_ff     <= phase_in;
            timer_ff     <= timer_in;
            bits_ff      <= bits_in;
            shift_ff     <= shift_in;
            scl_ff       <= scl_in;
            sda_ff       <= sda_in;
            read_ff      <= read_in;
            ack_ff       <= ack_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // response word register
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_scl_ff  <= scl_in;
         rsp_sda_ff  <= sda_in;
         rsp_busy_ff <= (op_in != CMD_NONE);
         rsp_done_ff <= done_in;
         rsp_read_ff <= read_in;
         rsp_ack_ff  <= ack_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_level = rsp_scl_ff;
   assign rsp_sda_level = rsp_sda_ff;
   assign rsp_busy_res  = rsp_busy_ff;
   assign rsp_done_res  = rsp_done_ff;
   assign rsp_read_byte = rsp_read_ff;
   assign rsp_ack_bit   = rsp_ack_ff;

endmodule

`default_nettype wire
